// ===== hdl/damage_rect_to_block_map_unit_macros.svh =====
// ============================================================================
// Assertion macros for the damage rectangle block map unit
// Shared property forms. Every use samples at i_clk and is off during reset.
// ============================================================================
`ifndef DAMAGE_RECT_TO_BLOCK_MAP_UNIT_MACROS_SVH
`define DAMAGE_RECT_TO_BLOCK_MAP_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRBM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DRBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/drbm_pkg.sv =====
// ============================================================================
// drbm_pkg
// Types and fixed constants of the damage rectangle to block map unit.
// ============================================================================
package drbm_pkg;

    // Request codes carried by the request type field.
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_MARK  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Configuration register indexes (byte address / 4).
    localparam logic [1:0] REG_ORIGIN_X     = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y     = 2'd1;
    localparam logic [1:0] REG_GRID_COLUMNS = 2'd2;
    localparam logic [1:0] REG_GRID_ROWS    = 2'd3;

    // Field widths.
    localparam int COORD_W = 13;
    localparam int DIM_W   = 14;
    localparam int GRID_W  = 8;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Reset values of the grid size registers.
    localparam logic [GRID_W-1:0] GRID_COLUMNS_RST = 8'd120;
    localparam logic [GRID_W-1:0] GRID_ROWS_RST    = 8'd68;

    // Reciprocal division: dividends stay below 2**DIVIDEND_W, and the
    // reciprocal is scaled by 2**DIV_SHIFT, enough for tile sizes up to 64.
    // The far corner of a rectangle can reach 8191 + 16383 - 1, so the
    // dividend needs one bit more than the size field.
    localparam int DIVIDEND_W = 15;
    localparam int DIV_SHIFT  = 20;
    localparam int PROD_W     = DIVIDEND_W + DIV_SHIFT;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVQ,
        ST_DIVR,
        ST_DIVC,
        ST_SPAN,
        ST_BASE,
        ST_ROW0,
        ST_RD,
        ST_WR,
        ST_RDRES,
        ST_DONE
    } t_state;

    // Control from the sequencer to the map store.
    typedef struct packed {
        logic wr_en;
        logic clear_all;
    } t_map_ctrl;

endpackage

// ===== hdl/damage_rect_to_block_map_unit.sv =====
// A mark divides its four dividends, clips the tile spans and then walks the map,
// reading and rewriting one word per covered row and map word. One request is in
// work at a time; the next one is taken at the earliest at the edge where the result can
// first be taken. A stalled result does not hold off the next request, only the handover
// of its own result to the output register.
// Reset is synchronous and active low; it empties the map and loads register defaults.
// ============================================================================
// damage_rect_to_block_map_unit
// Dirty tile bitmap over a grid of square blocks, marked from damage
// rectangles, cleared per frame and read one 64-bit word at a time.
// ============================================================================
module damage_rect_to_block_map_unit import drbm_pkg::*; #(
    parameter int BLOCK_SIZE  = 16,
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [COORD_W-1:0] i_rect_left,
    input  logic [COORD_W-1:0] i_rect_top,
    input  logic [DIM_W-1:0]   i_rect_width,
    input  logic [DIM_W-1:0]   i_rect_height,
    input  logic [7:0]         i_word_index,
    // Result channel.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [63:0]        o_map_word,
    output logic               o_rect_clipped,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

`include "damage_rect_to_block_map_unit_macros.svh"

    localparam int MAP_WORDS = (MAX_COLUMNS * MAX_ROWS + 63) / 64;
    localparam int WI_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BN_W      = WI_W + 6;
    localparam int CW        = $clog2(MAX_COLUMNS + 1);
    localparam int RW        = $clog2(MAX_ROWS + 1);
    localparam logic [DIV_SHIFT-1:0] RECIP = DIV_SHIFT'((1 << DIV_SHIFT) / BLOCK_SIZE);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] r_origin_x;
    logic [COORD_W-1:0] r_origin_y;
    logic [GRID_W-1:0]  r_grid_columns;
    logic [GRID_W-1:0]  r_grid_rows;
    logic               cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x     <= '0;
            r_origin_y     <= '0;
            r_grid_columns <= GRID_COLUMNS_RST;
            r_grid_rows    <= GRID_ROWS_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_ORIGIN_X:     r_origin_x     <= pwdata[COORD_W-1:0];
                REG_ORIGIN_Y:     r_origin_y     <= pwdata[COORD_W-1:0];
                REG_GRID_COLUMNS: r_grid_columns <= pwdata[GRID_W-1:0];
                REG_GRID_ROWS:    r_grid_rows    <= pwdata[GRID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (paddr[3:2])
            REG_ORIGIN_X:     prdata = PDATA_W'(r_origin_x);
            REG_ORIGIN_Y:     prdata = PDATA_W'(r_origin_y);
            REG_GRID_COLUMNS: prdata = PDATA_W'(r_grid_columns);
            REG_GRID_ROWS:    prdata = PDATA_W'(r_grid_rows);
            default:          prdata = '0;
        endcase
    end

    // Grid size saturated to the range the map holds; zero acts as one.
    logic [CW-1:0] cols;
    logic [RW-1:0] rows;

    always_comb begin
        if (r_grid_columns == '0) begin
            cols = CW'(1);
        end else if (32'(r_grid_columns) > MAX_COLUMNS) begin
            cols = CW'(MAX_COLUMNS);
        end else begin
            cols = CW'(r_grid_columns);
        end
        if (r_grid_rows == '0) begin
            rows = RW'(1);
        end else if (32'(r_grid_rows) > MAX_ROWS) begin
            rows = RW'(MAX_ROWS);
        end else begin
            rows = RW'(r_grid_rows);
        end
    end

    // ------------------------------------------------------------------
    // Request edge: far corners and dividends relative to the origin
    // ------------------------------------------------------------------
    logic                  in_acc;
    logic [DIM_W:0]        hx_sum;
    logic [DIM_W:0]        hy_sum;
    logic [DIM_W:0]        hx;
    logic [DIM_W:0]        hy;
    logic                  start_lo_x;
    logic                  start_lo_y;
    logic                  under_x;
    logic                  under_y;
    logic [DIVIDEND_W-1:0] in_div [4];

    assign in_acc     = i_in_valid && !o_in_stall;
    assign hx_sum     = (DIM_W+1)'(i_rect_left) + (DIM_W+1)'(i_rect_width) - (DIM_W+1)'(1);
    assign hy_sum     = (DIM_W+1)'(i_rect_top) + (DIM_W+1)'(i_rect_height) - (DIM_W+1)'(1);
    assign hx         = hx_sum;
    assign hy         = hy_sum;
    assign start_lo_x = i_rect_left < r_origin_x;
    assign start_lo_y = i_rect_top < r_origin_y;
    assign under_x    = hx < (DIM_W+1)'(r_origin_x);
    assign under_y    = hy < (DIM_W+1)'(r_origin_y);

    always_comb begin
        in_div[0] = start_lo_x ? '0 : DIVIDEND_W'(i_rect_left - r_origin_x);
        in_div[1] = under_x ? '0 : DIVIDEND_W'(hx - (DIM_W+1)'(r_origin_x));
        in_div[2] = start_lo_y ? '0 : DIVIDEND_W'(i_rect_top - r_origin_y);
        in_div[3] = under_y ? '0 : DIVIDEND_W'(hy - (DIM_W+1)'(r_origin_y));
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    t_state                r_state, n_state;
    logic [DIVIDEND_W-1:0] r_div [4], n_div [4];
    logic [DIVIDEND_W-1:0] r_quot [4], n_quot [4];
    logic [1:0]            r_k, n_k;
    logic [DIVIDEND_W-1:0] r_qest, n_qest;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic                  r_left_lo, n_left_lo;
    logic                  r_top_lo, n_top_lo;
    logic                  r_under_x, n_under_x;
    logic                  r_under_y, n_under_y;
    logic [CW-1:0]         r_c0, n_c0;
    logic [CW-1:0]         r_c1, n_c1;
    logic [RW-1:0]         r_row, n_row;
    logic [RW-1:0]         r_r1, n_r1;
    logic [BN_W-1:0]       r_rowbase, n_rowbase;
    logic [BN_W-1:0]       r_lo, n_lo;
    logic [BN_W-1:0]       r_hi, n_hi;
    logic                  r_last, n_last;
    logic [WI_W-1:0]       r_wi, n_wi;
    logic [63:0]           r_mask, n_mask;
    logic                  r_rd_ok, n_rd_ok;
    logic [63:0]           r_res_word, n_res_word;
    logic                  r_res_clip, n_res_clip;
    logic                  r_o_valid, n_o_valid;
    logic [63:0]           r_o_word, n_o_word;
    logic                  r_o_clip, n_o_clip;

    // Shared multiplier operands.
    logic [DIVIDEND_W-1:0] mul_a;
    logic [DIV_SHIFT-1:0]  mul_b;

    // Working values of the divide correction, span and walk steps.
    logic [DIVIDEND_W-1:0] div_rem;
    logic                  x_start_out, x_end_out, y_start_out, y_end_out;
    logic                  empty_x, empty_y;
    logic                  same_word;
    logic [5:0]            hi_b;
    logic [BN_W-1:0]       next_base;
    logic                  out_free;

    // Map store signals.
    t_map_ctrl             map_ctrl;
    logic [WI_W-1:0]       map_raddr;
    logic [63:0]           map_wdata;
    logic [63:0]           map_rdata;
    logic                  map_hit;

    assign div_rem     = r_div[r_k] - r_prod[DIVIDEND_W-1:0];
    assign x_start_out = 32'(r_quot[0]) >= 32'(cols);
    assign x_end_out   = 32'(r_quot[1]) >= 32'(cols);
    assign y_start_out = 32'(r_quot[2]) >= 32'(rows);
    assign y_end_out   = 32'(r_quot[3]) >= 32'(rows);
    assign empty_x     = r_under_x || x_start_out;
    assign empty_y     = r_under_y || y_start_out;
    assign same_word   = r_hi[BN_W-1:6] == r_lo[BN_W-1:6];
    assign hi_b        = same_word ? r_hi[5:0] : 6'd63;
    assign next_base   = r_rowbase + BN_W'(cols);
    assign out_free    = !r_o_valid || !i_out_stall;
    assign map_wdata   = (map_hit ? map_rdata : 64'd0) | r_mask;

    // Next state and outputs of the sequencer.
    always_comb begin
        n_state    = r_state;
        n_div      = r_div;
        n_quot     = r_quot;
        n_k        = r_k;
        n_qest     = r_qest;
        n_left_lo  = r_left_lo;
        n_top_lo   = r_top_lo;
        n_under_x  = r_under_x;
        n_under_y  = r_under_y;
        n_c0       = r_c0;
        n_c1       = r_c1;
        n_row      = r_row;
        n_r1       = r_r1;
        n_rowbase  = r_rowbase;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_last     = r_last;
        n_wi       = r_wi;
        n_mask     = r_mask;
        n_rd_ok    = r_rd_ok;
        n_res_word = r_res_word;
        n_res_clip = r_res_clip;
        n_o_valid  = r_o_valid && i_out_stall;
        n_o_word   = r_o_word;
        n_o_clip   = r_o_clip;
        mul_a      = '0;
        mul_b      = '0;
        map_ctrl   = '0;
        map_raddr  = r_lo[BN_W-1:6];

        case (r_state)
            // Take a request; a read addresses the map at once.
            ST_IDLE: begin
                map_raddr = WI_W'(i_word_index);
                if (in_acc) begin
                    n_res_word = '0;
                    n_res_clip = 1'b0;
                    n_div      = in_div;
                    n_k        = '0;
                    n_left_lo  = start_lo_x;
                    n_top_lo   = start_lo_y;
                    n_under_x  = under_x;
                    n_under_y  = under_y;
                    n_rd_ok    = 32'(i_word_index) < MAP_WORDS;
                    case (i_req_type)
                        REQ_CLEAR: begin
                            map_ctrl.clear_all = 1'b1;
                            n_state            = ST_DONE;
                        end
                        REQ_MARK: begin
                            if (i_rect_width != '0 && i_rect_height != '0) begin
                                n_state = ST_DIVQ;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        REQ_READ: n_state = ST_RDRES;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end

            // Quotient estimate: dividend times the scaled reciprocal.
            ST_DIVQ: begin
                mul_a   = r_div[r_k];
                mul_b   = RECIP;
                n_state = ST_DIVR;
            end

            // Multiply the estimate back by the tile size.
            ST_DIVR: begin
                n_qest  = r_prod[DIV_SHIFT +: DIVIDEND_W];
                mul_a   = r_prod[DIV_SHIFT +: DIVIDEND_W];
                mul_b   = DIV_SHIFT'(BLOCK_SIZE);
                n_state = ST_DIVC;
            end

            // The estimate is at most one low; fix it from the remainder.
            ST_DIVC: begin
                n_quot[r_k] = r_qest + DIVIDEND_W'(32'(div_rem) >= BLOCK_SIZE);
                n_k         = r_k + 2'd1;
                n_state     = (r_k == 2'd3) ? ST_SPAN : ST_DIVQ;
            end

            // Clip the tile spans to the grid.
            ST_SPAN: begin
                n_res_clip = r_under_x || r_left_lo || x_start_out || x_end_out ||
                             r_under_y || r_top_lo || y_start_out || y_end_out;
                n_c0       = CW'(r_quot[0]);
                n_c1       = x_end_out ? cols - CW'(1) : CW'(r_quot[1]);
                n_row      = RW'(r_quot[2]);
                n_r1       = y_end_out ? rows - RW'(1) : RW'(r_quot[3]);
                n_state    = (empty_x || empty_y) ? ST_DONE : ST_BASE;
            end

            // Block number of the first covered row.
            ST_BASE: begin
                mul_a   = DIVIDEND_W'(r_row);
                mul_b   = DIV_SHIFT'(cols);
                n_state = ST_ROW0;
            end

            ST_ROW0: begin
                n_rowbase = r_prod[BN_W-1:0];
                n_lo      = r_prod[BN_W-1:0] + BN_W'(r_c0);
                n_hi      = r_prod[BN_W-1:0] + BN_W'(r_c1);
                n_last    = 1'b0;
                n_state   = ST_RD;
            end

            // Read the word under the walk pointer and build its bit mask.
            ST_RD: begin
                n_wi   = r_lo[BN_W-1:6];
                n_mask = ({64{1'b1}} << r_lo[5:0]) & ({64{1'b1}} >> (6'd63 - hi_b));
                if (!same_word) begin
                    n_lo = {r_lo[BN_W-1:6] + WI_W'(1), 6'd0};
                end else if (r_row == r_r1) begin
                    n_last = 1'b1;
                end else begin
                    n_row     = r_row + RW'(1);
                    n_rowbase = next_base;
                    n_lo      = next_base + BN_W'(r_c0);
                    n_hi      = next_base + BN_W'(r_c1);
                end
                n_state = ST_WR;
            end

            // Merge the mask into the word and write it back.
            ST_WR: begin
                map_ctrl.wr_en = 1'b1;
                n_state        = r_last ? ST_DONE : ST_RD;
            end

            ST_RDRES: begin
                n_res_word = (r_rd_ok && map_hit) ? map_rdata : 64'd0;
                n_state    = ST_DONE;
            end

            // Hand the result to the output register once it is free.
            ST_DONE: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_word  = r_res_word;
                    n_o_clip  = r_res_clip;
                    n_state   = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
    end

    // Shared multiplier with its product register.
    assign n_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_div      <= n_div;
        r_quot     <= n_quot;
        r_k        <= n_k;
        r_qest     <= n_qest;
        r_prod     <= n_prod;
        r_left_lo  <= n_left_lo;
        r_top_lo   <= n_top_lo;
        r_under_x  <= n_under_x;
        r_under_y  <= n_under_y;
        r_c0       <= n_c0;
        r_c1       <= n_c1;
        r_row      <= n_row;
        r_r1       <= n_r1;
        r_rowbase  <= n_rowbase;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_last     <= n_last;
        r_wi       <= n_wi;
        r_mask     <= n_mask;
        r_rd_ok    <= n_rd_ok;
        r_res_word <= n_res_word;
        r_res_clip <= n_res_clip;
        r_o_word   <= n_o_word;
        r_o_clip   <= n_o_clip;
    end

    // ------------------------------------------------------------------
    // Map storage
    // ------------------------------------------------------------------
    drbm_map_store #(
        .WORDS (MAP_WORDS)
    ) u_map_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (map_ctrl),
        .i_waddr (r_wi),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata),
        .o_hit   (map_hit)
    );

    assign o_in_stall     = r_state != ST_IDLE;
    assign o_out_valid    = r_o_valid;
    assign o_map_word     = r_o_word;
    assign o_rect_clipped = r_o_clip;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic mark_go;
    logic rem_ok;
    logic walk_ok;

    assign mark_go = in_acc && (i_req_type == REQ_MARK) &&
                     (i_rect_width != '0) && (i_rect_height != '0);
    assign rem_ok  = 32'(div_rem) < 2 * BLOCK_SIZE;
    assign walk_ok = (r_row <= r_r1) && (r_lo <= r_hi);

    `DRBM_ASSERT_NEXT(a_mark_go, mark_go, r_state == ST_DIVQ, "mark did not start dividing")
    `DRBM_ASSERT_IMPL(a_div_close, r_state == ST_DIVC, rem_ok, "quotient estimate too low")
    `DRBM_ASSERT_IMPL(a_walk_in_bounds, r_state == ST_RD, walk_ok, "map walk ran past its span")
    `DRBM_ASSERT_IMPL(a_mask_set, r_state == ST_WR, r_mask != '0, "map write with an empty mask")

endmodule

// ===== hdl/drbm_map_store.sv =====
// ============================================================================
// drbm_map_store
// Dirty map memory of 64-bit words with one valid bit per word. A clear
// resets only the valid bits; each read returns the word with its valid bit.
// ============================================================================
module drbm_map_store import drbm_pkg::*; #(
    parameter int  WORDS = 256,
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_map_ctrl     i_ctrl,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata,
    output logic          o_hit
);

    logic [63:0] r_mem [WORDS];
    logic        r_valid [WORDS];
    logic [63:0] r_rdata;
    logic        r_hit;

    // Word storage with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
        r_hit   <= r_valid[i_raddr];
    end

    // Valid bits: cleared by reset and by a clear request, set by a write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear_all) begin
            for (int i = 0; i < WORDS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (i_ctrl.wr_en) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    assign o_rdata = r_rdata;
    assign o_hit   = r_hit;

endmodule

// ===== dv/damage_rect_to_block_map_unit_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// damage_rect_to_block_map_unit_tb
// Self-checking bench for the dirty tile bitmap. Requests from a queue are
// driven with random sender gaps, and results are taken with random and long
// receiver stalls. A tile map model predicts every result when its request is
// accepted, and the results are compared in order, field by field.
// ============================================================================
module damage_rect_to_block_map_unit_tb;
    import drbm_pkg::*;

    localparam int unsigned TILE_PX       = 16;
    localparam int unsigned GRID_MAX_COLS = 128;
    localparam int unsigned GRID_MAX_ROWS = 128;
    localparam int unsigned MAP_DEPTH     = (GRID_MAX_COLS * GRID_MAX_ROWS + 63) / 64;
    localparam logic [1:0]  REQ_UNUSED    = 2'd3;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned RUN_LIMIT     = 3000000;

    typedef struct packed {
        logic [1:0]         kind;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [7:0]         word_idx;
    } t_req_item;

    typedef struct packed {
        logic [63:0] map_word;
        logic        clipped;
    } t_map_result;

    // Clock and reset.
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Request and result channels.
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    t_req_item   cur_req = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] o_map_word;
    logic        o_rect_clipped;

    // Configuration port.
    logic               apb_sel = 1'b0;
    logic               apb_enable = 1'b0;
    logic               apb_write = 1'b0;
    logic [PADDR_W-1:0] apb_addr = '0;
    logic [PDATA_W-1:0] apb_wdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    damage_rect_to_block_map_unit #(
        .BLOCK_SIZE (TILE_PX),
        .MAX_COLUMNS(GRID_MAX_COLS),
        .MAX_ROWS   (GRID_MAX_ROWS)
    ) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (cur_req.kind),
        .i_rect_left   (cur_req.left),
        .i_rect_top    (cur_req.top),
        .i_rect_width  (cur_req.width),
        .i_rect_height (cur_req.height),
        .i_word_index  (cur_req.word_idx),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_map_word    (o_map_word),
        .o_rect_clipped(o_rect_clipped),
        .psel          (apb_sel),
        .penable       (apb_enable),
        .pwrite        (apb_write),
        .paddr         (apb_addr),
        .pwdata        (apb_wdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Model state: the tile map and the configuration registers.
    logic [63:0]        tile_map [MAP_DEPTH];
    logic [COORD_W-1:0] origin_x_reg = '0;
    logic [COORD_W-1:0] origin_y_reg = '0;
    logic [GRID_W-1:0]  grid_cols_reg = GRID_COLUMNS_RST;
    logic [GRID_W-1:0]  grid_rows_reg = GRID_ROWS_RST;

    t_req_item   pending_requests[$];
    t_map_result expected_results[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_start = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned errors = 0;

    int unsigned n_marks = 0;
    int unsigned n_clipped = 0;
    int unsigned n_reads = 0;
    int unsigned n_reads_set = 0;
    int unsigned n_clears = 0;
    int unsigned n_unused = 0;
    int unsigned n_settings = 0;

    // Grid size as the block uses it: saturated to 1..maximum.
    function automatic int unsigned eff_dim(logic [GRID_W-1:0] v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // Tile range covered along one axis; returns 0 when no tile is covered.
    function automatic bit tile_span(int unsigned pos, int unsigned len, int unsigned org,
                                     int unsigned tiles, output int unsigned first,
                                     output int unsigned last, inout bit cut);
        int unsigned hi_px;
        hi_px = pos + len - 1;
        first = 0;
        last = 0;
        if (hi_px < org) begin
            cut = 1'b1;
            return 1'b0;
        end
        if (pos < org) begin
            cut = 1'b1;
            first = 0;
        end else begin
            first = (pos - org) / TILE_PX;
        end
        last = (hi_px - org) / TILE_PX;
        if (first >= tiles) begin
            cut = 1'b1;
            return 1'b0;
        end
        if (last >= tiles) begin
            cut = 1'b1;
            last = tiles - 1;
        end
        return 1'b1;
    endfunction

    // Applies one request to the tile map and returns the result it gives.
    function automatic t_map_result apply_request(t_req_item rq);
        t_map_result res;
        int unsigned cols, rows, c0, c1, r0, r1, blk;
        bit cut, ok_x, ok_y;
        res = '0;
        cut = 1'b0;
        case (rq.kind)
            REQ_CLEAR: begin
                foreach (tile_map[i]) tile_map[i] = '0;
            end
            REQ_MARK: begin
                if (rq.width != 0 && rq.height != 0) begin
                    cols = eff_dim(grid_cols_reg, GRID_MAX_COLS);
                    rows = eff_dim(grid_rows_reg, GRID_MAX_ROWS);
                    ok_x = tile_span(rq.left, rq.width, origin_x_reg, cols, c0, c1, cut);
                    ok_y = tile_span(rq.top, rq.height, origin_y_reg, rows, r0, r1, cut);
                    if (ok_x && ok_y) begin
                        for (int unsigned r = r0; r <= r1; r++) begin
                            for (int unsigned c = c0; c <= c1; c++) begin
                                blk = r * cols + c;
                                if (blk / 64 < MAP_DEPTH) tile_map[blk / 64][blk % 64] = 1'b1;
                            end
                        end
                    end
                end
            end
            REQ_READ: begin
                if (rq.word_idx < MAP_DEPTH) res.map_word = tile_map[rq.word_idx];
            end
            default: begin
            end
        endcase
        res.clipped = cut;
        return res;
    endfunction

    // Request driver: presents queued requests with random gaps.
    always @(posedge clk) begin : drive_requests
        t_req_item   next_req;
        t_map_result res;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!(in_valid && o_in_stall)) begin
            if (in_valid) begin
                res = apply_request(cur_req);
                expected_results.push_back(res);
                case (cur_req.kind)
                    REQ_CLEAR: n_clears++;
                    REQ_MARK: begin
                        n_marks++;
                        if (res.clipped) n_clipped++;
                    end
                    REQ_READ: begin
                        n_reads++;
                        if (res.map_word != 0) n_reads_set++;
                    end
                    default: n_unused++;
                endcase
            end
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_req = pending_requests.pop_front();
                cur_req <= next_req;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted down on its own.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: compares each accepted result with the oldest prediction.
    always @(posedge clk) begin : check_results
        t_map_result want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: map_word %h clipped %b",
                             $time, o_map_word, o_rect_clipped);
                end else begin
                    want = expected_results.pop_front();
                    if (o_map_word !== want.map_word) begin
                        errors++;
                        $display("%0t: map_word mismatch: expected %h actual %h",
                                 $time, want.map_word, o_map_word);
                    end
                    if (o_rect_clipped !== want.clipped) begin
                        errors++;
                        $display("%0t: rect_clipped mismatch: expected %b actual %b",
                                 $time, want.clipped, o_rect_clipped);
                    end
                end
            end
            out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Register write through the configuration port; the model copy follows it.
    task automatic write_reg(input logic [1:0] reg_idx, input logic [PDATA_W-1:0] value);
        @(posedge clk);
        apb_sel <= 1'b1;
        apb_enable <= 1'b0;
        apb_write <= 1'b1;
        apb_addr <= {reg_idx, 2'b00};
        apb_wdata <= value;
        @(posedge clk);
        apb_enable <= 1'b1;
        do @(posedge clk); while (!pready);
        apb_sel <= 1'b0;
        apb_enable <= 1'b0;
        apb_write <= 1'b0;
        case (reg_idx)
            REG_ORIGIN_X:     origin_x_reg = value[COORD_W-1:0];
            REG_ORIGIN_Y:     origin_y_reg = value[COORD_W-1:0];
            REG_GRID_COLUMNS: grid_cols_reg = value[GRID_W-1:0];
            default:          grid_rows_reg = value[GRID_W-1:0];
        endcase
        @(negedge clk);
    endtask

    // Writes all four registers; unused upper data bits get random junk at times.
    task automatic configure_grid(input int unsigned ox, input int unsigned oy,
                                  input int unsigned cols, input int unsigned rows);
        logic [PDATA_W-1:0] junk;
        junk = $urandom_range(0, 1) ? $urandom : '0;
        write_reg(REG_ORIGIN_X, (junk & ~32'h1FFF) | ox);
        write_reg(REG_ORIGIN_Y, (junk & ~32'h1FFF) | oy);
        write_reg(REG_GRID_COLUMNS, (junk & ~32'hFF) | cols);
        write_reg(REG_GRID_ROWS, (junk & ~32'hFF) | rows);
        n_settings++;
    endtask

    // Waits until no request is pending or in flight, then lets the block settle.
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    function automatic t_req_item make_req(logic [1:0] kind, int unsigned left,
                                           int unsigned top, int unsigned w,
                                           int unsigned h, int unsigned idx);
        t_req_item rq;
        rq.kind = kind;
        rq.left = COORD_W'(left);
        rq.top = COORD_W'(top);
        rq.width = DIM_W'(w);
        rq.height = DIM_W'(h);
        rq.word_idx = 8'(idx);
        return rq;
    endfunction

    // Position along one axis, mostly on the grid, sometimes before it or anywhere.
    function automatic logic [COORD_W-1:0] rand_pos(logic [COORD_W-1:0] org,
                                                    int unsigned tiles);
        int unsigned sel, p;
        sel = $urandom_range(0, 19);
        if (sel < 14) p = org + $urandom_range(0, tiles * TILE_PX + TILE_PX);
        else if (sel < 17) p = org - $urandom_range(1, 64);
        else p = $urandom_range(0, 8191);
        return p[COORD_W-1:0];
    endfunction

    // Rectangle size: mostly small, some up to the grid, a few zero or huge.
    function automatic logic [DIM_W-1:0] rand_len(int unsigned tiles);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return DIM_W'($urandom_range(1, 40));
        if (sel < 80) return DIM_W'($urandom_range(1, tiles * TILE_PX));
        if (sel < 88) return '0;
        if (sel < 95) return DIM_W'($urandom_range(0, 8192));
        return DIM_W'($urandom_range(0, 16383));
    endfunction

    function automatic t_req_item random_request(logic [1:0] kind);
        t_req_item rq;
        int unsigned cols, rows, used_words;
        cols = eff_dim(grid_cols_reg, GRID_MAX_COLS);
        rows = eff_dim(grid_rows_reg, GRID_MAX_ROWS);
        used_words = (cols * rows - 1) / 64;
        rq = make_req(kind, $urandom_range(0, 8191), $urandom_range(0, 8191),
                      $urandom_range(0, 16383), $urandom_range(0, 16383),
                      $urandom_range(0, 255));
        if (kind == REQ_MARK) begin
            rq.left = rand_pos(origin_x_reg, cols);
            rq.top = rand_pos(origin_y_reg, rows);
            rq.width = rand_len(cols);
            rq.height = rand_len(rows);
        end else if (kind == REQ_READ && $urandom_range(0, 99) < 85) begin
            rq.word_idx = 8'($urandom_range(0, used_words));
        end
        return rq;
    endfunction

    // Queues frames: mostly a clear, a burst of marks with reads and unused requests in between, then reads.
    task automatic queue_frames(input int unsigned n_items);
        int unsigned n_rects;
        while (pending_requests.size() < n_items) begin
            if ($urandom_range(0, 9) != 0) pending_requests.push_back(random_request(REQ_CLEAR));
            n_rects = $urandom_range(1, 8);
            repeat (n_rects) begin
                pending_requests.push_back(random_request(REQ_MARK));
                if ($urandom_range(0, 4) == 0)
                    pending_requests.push_back(random_request(REQ_READ));
                if ($urandom_range(0, 19) == 0)
                    pending_requests.push_back(random_request(REQ_UNUSED));
            end
            repeat ($urandom_range(1, 4)) pending_requests.push_back(random_request(REQ_READ));
        end
    endtask

    task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                             input int unsigned n_items, input bit with_holdoff);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        queue_frames(n_items);
        if (with_holdoff) begin
            // Output held off while requests keep coming, so the input backs up.
            @(negedge clk);
            hold_start = 1'b1;
            @(negedge clk);
            hold_start = 1'b0;
        end
        wait_drained();
    endtask

    initial begin
        foreach (tile_map[i]) tile_map[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests at the reset configuration (120 x 68 tiles).
        pending_requests.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_req(REQ_MARK, 0, 0, 16, 16, 0));
        pending_requests.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_req(REQ_MARK, 8191, 8191, 1, 1, 0));
        pending_requests.push_back(make_req(REQ_MARK, 1900, 1000, 100, 200, 0));
        pending_requests.push_back(make_req(REQ_MARK, 0, 0, 0, 50, 0));
        pending_requests.push_back(make_req(REQ_MARK, 0, 0, 50, 0, 0));
        pending_requests.push_back(make_req(REQ_MARK, 0, 0, 16383, 16383, 0));
        pending_requests.push_back(make_req(REQ_READ, 0, 0, 0, 0, 127));
        pending_requests.push_back(make_req(REQ_READ, 0, 0, 0, 0, 255));
        pending_requests.push_back(make_req(REQ_UNUSED, 8191, 8191, 16383, 16383, 255));
        pending_requests.push_back(make_req(REQ_CLEAR, 8191, 8191, 16383, 16383, 255));
        pending_requests.push_back(make_req(REQ_READ, 0, 0, 0, 0, 127));
        pending_requests.push_back(make_req(REQ_READ, 0, 0, 0, 0, 64));
        wait_drained();

        // Origin offsets; a column count of 0 acts as 1 and 255 saturates to 128 rows.
        configure_grid(100, 50, 0, 255);
        pending_requests.push_back(make_req(REQ_MARK, 90, 40, 20, 20, 0));
        pending_requests.push_back(make_req(REQ_MARK, 0, 0, 50, 50, 0));
        pending_requests.push_back(make_req(REQ_MARK, 100, 50, 16, 2048, 0));
        pending_requests.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_req(REQ_READ, 0, 0, 0, 0, 1));
        pending_requests.push_back(make_req(REQ_READ, 0, 0, 0, 0, 2));
        pending_requests.push_back(make_req(REQ_MARK, 116, 50, 1, 1, 0));
        pending_requests.push_back(make_req(REQ_CLEAR, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0));
        wait_drained();

        // Random frames over several grid settings and flow control patterns.
        configure_grid(0, 0, GRID_MAX_COLS, GRID_MAX_ROWS);
        run_phase(0, 0, 175, 1'b0);
        configure_grid(8191, 8191, 1, 1);
        run_phase(62, 0, 120, 1'b0);
        configure_grid($urandom_range(0, 2000), $urandom_range(0, 2000),
                       $urandom_range(0, 255), $urandom_range(0, 255));
        run_phase(0, 62, 175, 1'b0);
        configure_grid($urandom_range(0, 8191), $urandom_range(0, 8191),
                       $urandom_range(1, 128), $urandom_range(1, 128));
        run_phase(21, 21, 175, 1'b0);
        configure_grid(0, 0, GRID_COLUMNS_RST, GRID_ROWS_RST);
        run_phase(0, 0, 175, 1'b1);
        configure_grid($urandom_range(0, 1500), $urandom_range(0, 1500),
                       $urandom_range(0, 255), $urandom_range(0, 255));
        run_phase(21, 21, 175, 1'b0);

        repeat (40) @(negedge clk);
        if (expected_results.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        end

        $display("Covered %0d marks (%0d clipped), %0d reads (%0d nonzero), %0d clears,",
                 n_marks, n_clipped, n_reads, n_reads_set, n_clears);
        $display("%0d unused requests over %0d grid settings, with random and long stalls",
                 n_unused, n_settings);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
